// ===== rtl/core/civ_pkg.sv =====
// Shared types, constants and tables of the calibration image validator.
package civ_pkg;

   // Image geometry.
   localparam int unsigned IMAGE_BYTES = 13483;
   localparam int unsigned POS_W = 14;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(IMAGE_BYTES - 1);

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_AWB_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_VENDOR_ID   = 3'd1;
   localparam logic [2:0] CSR_LENS_ID     = 3'd2;
   localparam logic [2:0] CSR_ACTUATOR_ID = 3'd3;
   localparam logic [2:0] CSR_DRIVER_ID   = 3'd4;
   localparam logic [2:0] CSR_PLATFORM_ID = 3'd5;

   // Register reset values.
   localparam logic [31:0] AWB_LIMIT_RESET   = 32'd10485;
   localparam logic [7:0]  VENDOR_ID_RESET   = 8'd8;
   localparam logic [7:0]  LENS_ID_RESET     = 8'd7;
   localparam logic [7:0]  ACTUATOR_ID_RESET = 8'd16;
   localparam logic [7:0]  DRIVER_ID_RESET   = 8'd2;
   localparam logic [7:0]  PLATFORM_ID_RESET = 8'd3;

   // Result status codes.
   localparam logic [2:0] STATUS_PASS        = 3'd0;
   localparam logic [2:0] STATUS_READ_FAILED = 3'd1;
   localparam logic [2:0] STATUS_GROUP       = 3'd2;
   localparam logic [2:0] STATUS_MODULE_INFO = 3'd3;
   localparam logic [2:0] STATUS_CHECKSUM    = 3'd4;
   localparam logic [2:0] STATUS_AWB_RANGE   = 3'd5;

   // Module identity byte addresses.
   localparam logic [POS_W-1:0] POS_VENDOR   = 14'h0001;
   localparam logic [POS_W-1:0] POS_PLATFORM = 14'h0002;
   localparam logic [POS_W-1:0] POS_LENS     = 14'h0008;
   localparam logic [POS_W-1:0] POS_ACTUATOR = 14'h0009;
   localparam logic [POS_W-1:0] POS_DRIVER   = 14'h000A;
   localparam logic [POS_W-1:0] POS_VER0     = 14'h000B;
   localparam logic [POS_W-1:0] POS_VER1     = 14'h000C;
   localparam logic [POS_W-1:0] POS_VER2     = 14'h000D;
   localparam logic [POS_W-1:0] POS_VER3     = 14'h000E;

   // White balance word ranges: high then low color temperature.
   localparam logic [POS_W-1:0] AWB_HI_FIRST = 14'h0061;
   localparam logic [POS_W-1:0] AWB_HI_LAST  = 14'h006C;
   localparam logic [POS_W-1:0] AWB_LO_FIRST = 14'h0071;
   localparam logic [POS_W-1:0] AWB_LO_LAST  = 14'h007C;
   localparam int unsigned AWB_WORDS = 12;
   localparam int unsigned AWB_IDX_W = 4;

   // Checksum sections.
   localparam int unsigned NUM_SECTIONS = 11;
   localparam logic [POS_W-1:0] SEC_FLAG [NUM_SECTIONS] = '{
      14'h0000, 14'h0020, 14'h0045, 14'h3494, 14'h0060, 14'h0D20,
      14'h1470, 14'h1662, 14'h1A9D, 14'h2EE9, 14'h33D2};
   localparam logic [POS_W-1:0] SEC_SUM_AT [NUM_SECTIONS] = '{
      14'h001F, 14'h0044, 14'h005F, 14'h34AA, 14'h009F, 14'h146F,
      14'h1661, 14'h1A4F, 14'h2EE8, 14'h33D1, 14'h3493};
   localparam logic [NUM_SECTIONS-1:0] SEC_FLAG_CHECKED = 11'b10011111111;

   // Deviation arithmetic.
   localparam int unsigned AWB_SHIFT = 20;
   localparam int unsigned DIVIDEND_W = 32 + AWB_SHIFT;
   localparam int unsigned DIVISOR_W = 32;
   localparam int unsigned TOTAL_W = DIVIDEND_W + 2;
   localparam int unsigned DIV_CNT_W = 6;

   typedef struct packed {
      logic [7:0] image_byte;
      logic       read_failed;
   } civ_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] failed_section;
   } civ_rsp_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } civ_div_result_type;

endpackage

// ===== rtl/core/civ_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module civ_div
   import civ_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output civ_div_result_type    result
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] work_ff, work_in;
   logic [DIVISOR_W:0]    trial;
   logic                  take;

   // One trial subtraction per cycle; quotient bits shift in as dividend bits leave.
   always_comb begin
      trial      = {rem_ff, work_ff[DIVIDEND_W-1]};
      take       = (trial >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      work_in    = work_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(DIVIDEND_W);
         divisor_in = divisor;
         rem_in     = '0;
         work_in    = dividend;
      end else if (busy_ff) begin
         rem_in   = take ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         work_in  = {work_ff[DIVIDEND_W-2:0], take};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      work_ff    <= work_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = work_ff;

endmodule

// ===== rtl/core/calibration_image_validator.sv =====
// Top level of the calibration image validator.
// The block takes one image byte per cycle in address order and gives one result
// item after the last byte, or at once for a byte marked as a read failure. After
// the last byte a decide state settles the flag, identity and checksum verdicts; when
// those pass, the white balance check runs on a shared 16x16 multiplier and a
// one-bit-per-cycle divider, one color channel after another, for both color
// temperatures. Input stalls from the last byte until the result is given and
// while a result waits to be taken.
module calibration_image_validator
   import civ_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  civ_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output civ_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DECIDE = 8'b0000_0010,
      ST_LOAD_U = 8'b0000_0100,
      ST_LOAD_G = 8'b0000_1000,
      ST_MUL_D  = 8'b0001_0000,
      ST_MUL_G  = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_ACCUM  = 8'b1000_0000
   } civ_state_type;

   civ_state_type state_ff, state_in;

   logic [31:0] awb_limit_ff;
   logic [7:0]  vendor_id_ff, lens_id_ff, actuator_id_ff, driver_id_ff, platform_id_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [3:0]       fail_ff, fail_in;
   logic             group_ok_ff, group_ok_in;
   logic             module_ok_ff, module_ok_in;

   logic [7:0] awb_hi_ff [AWB_WORDS];
   logic [7:0] awb_lo_ff [AWB_WORDS];

   logic             check_ff, check_in;
   logic [1:0]       chan_ff, chan_in;
   logic [15:0]      unit_ff, unit_in;
   logic [15:0]      gold_ff, gold_in;
   logic [31:0]      prod_ff, prod_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic        rsp_valid_ff, rsp_valid_in;
   civ_rsp_type rsp_ff, rsp_in;

   logic        accept;
   logic [7:0]  b;
   logic        module_bad;
   logic        awb_we;
   logic [AWB_IDX_W-1:0] awb_wr_idx, awb_rd_idx;
   logic [6:0]  awb_rel;
   logic [15:0] rd_word;
   logic [15:0] diff, mul_op;
   logic [31:0] mul_product;
   logic [8:0]  sum_add;
   logic [7:0]  sum_expect;
   logic [TOTAL_W-1:0] total_sum;
   logic        div_start;
   civ_div_result_type div_result;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign b         = req_data.image_byte;

   // Module identity and version bytes.
   always_comb begin
      module_bad = 1'b0;
      unique case (pos_ff) inside
         POS_VENDOR:   module_bad = (b != vendor_id_ff);
         POS_PLATFORM: module_bad = (b != platform_id_ff);
         POS_LENS:     module_bad = (b != lens_id_ff);
         POS_ACTUATOR: module_bad = (b != actuator_id_ff);
         POS_DRIVER:   module_bad = (b != driver_id_ff);
         POS_VER0, POS_VER1, POS_VER2: module_bad = (b != 8'd0);
         POS_VER3:     module_bad = (b != 8'd0) && (b != 8'd2) && (b != 8'd3);
         default:      module_bad = 1'b0;
      endcase
   end

   // White balance byte capture: even offsets carry the high byte.
   always_comb begin
      awb_rel    = pos_ff[6:0] - AWB_HI_FIRST[6:0];
      awb_we     = 1'b0;
      awb_wr_idx = '0;
      if (pos_ff >= AWB_HI_FIRST && pos_ff <= AWB_HI_LAST) begin
         awb_we     = accept && !req_data.read_failed;
         awb_wr_idx = AWB_IDX_W'(awb_rel[6:1]);
      end else if (pos_ff >= AWB_LO_FIRST && pos_ff <= AWB_LO_LAST) begin
         awb_we     = accept && !req_data.read_failed;
         awb_wr_idx = AWB_IDX_W'(6) + AWB_IDX_W'(awb_rel[6:1] - 6'd8);
      end
   end

   always_ff @(posedge clock) begin
      if (awb_we) begin
         if (!awb_rel[0]) begin
            awb_hi_ff[awb_wr_idx] <= b;
            awb_lo_ff[awb_wr_idx] <= 8'd0;
         end else begin
            awb_lo_ff[awb_wr_idx] <= b;
         end
      end
   end

   // Word read for the sequencer: unit words first, golden words three later.
   assign awb_rd_idx = (check_ff ? AWB_IDX_W'(6) : AWB_IDX_W'(0)) + AWB_IDX_W'(chan_ff)
                     + ((state_ff == ST_LOAD_G) ? AWB_IDX_W'(3) : AWB_IDX_W'(0));
   assign rd_word    = {awb_hi_ff[awb_rd_idx], awb_lo_ff[awb_rd_idx]};

   // Shared multiplier: squared deviation, then squared golden value.
   assign diff        = (unit_ff > gold_ff) ? (unit_ff - gold_ff) : (gold_ff - unit_ff);
   assign mul_op      = (state_ff == ST_MUL_G) ? gold_ff : diff;
   assign mul_product = mul_op * mul_op;

   assign div_start = (state_ff == ST_MUL_G);

   civ_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({prod_ff, AWB_SHIFT'(0)}),
      .divisor  (mul_product),
      .result   (div_result)
   );

   assign sum_add    = {1'b0, sum_ff} + {1'b0, b};
   assign sum_expect = sum_ff + 8'd1;
   assign total_sum  = total_ff + TOTAL_W'(div_result.quotient);

   // Byte handling and the result sequencer.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      fail_in      = fail_ff;
      group_ok_in  = group_ok_ff;
      module_ok_in = module_ok_ff;
      check_in     = check_ff;
      chan_in      = chan_ff;
      unit_in      = unit_ff;
      gold_in      = gold_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.read_failed) begin
                  pos_in       = '0;
                  sum_in       = '0;
                  fail_in      = '0;
                  group_ok_in  = 1'b1;
                  module_ok_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_READ_FAILED, failed_section: 4'd0};
               end else begin
                  if (module_bad) module_ok_in = 1'b0;
                  for (int s = 0; s < NUM_SECTIONS; s++) begin
                     if (pos_ff == SEC_FLAG[s]) begin
                        sum_in = '0;
                        if (SEC_FLAG_CHECKED[s] && b != 8'd1) group_ok_in = 1'b0;
                     end else if (pos_ff > SEC_FLAG[s] && pos_ff < SEC_SUM_AT[s]) begin
                        sum_in = (sum_add >= 9'd255) ? 8'(sum_add - 9'd255) : sum_add[7:0];
                     end else if (pos_ff == SEC_SUM_AT[s]) begin
                        if (b != sum_expect && (fail_ff == 4'd0 || 4'(s + 1) < fail_ff))
                           fail_in = 4'(s + 1);
                     end
                  end
                  if (pos_ff == LAST_POS) state_in = ST_DECIDE;
                  else pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_DECIDE: begin
            pos_in       = '0;
            sum_in       = '0;
            fail_in      = '0;
            group_ok_in  = 1'b1;
            module_ok_in = 1'b1;
            check_in     = 1'b0;
            chan_in      = '0;
            total_in     = '0;
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (!group_ok_ff) begin
               rsp_in = '{status: STATUS_GROUP, failed_section: 4'd0};
            end else if (!module_ok_ff) begin
               rsp_in = '{status: STATUS_MODULE_INFO, failed_section: 4'd0};
            end else if (fail_ff != 4'd0) begin
               rsp_in = '{status: STATUS_CHECKSUM, failed_section: fail_ff};
            end else begin
               rsp_valid_in = 1'b0;
               state_in     = ST_LOAD_U;
            end
         end
         ST_LOAD_U: begin
            unit_in  = rd_word;
            state_in = ST_LOAD_G;
         end
         ST_LOAD_G: begin
            gold_in = rd_word;
            if (rd_word == 16'd0) begin
               // A zero golden value fails the check outright.
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in = '{status: STATUS_AWB_RANGE, failed_section: {3'd0, 1'b1} + 4'(check_ff)};
            end else begin
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            prod_in  = mul_product;
            state_in = ST_MUL_G;
         end
         ST_MUL_G: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_result.done) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            total_in = total_sum;
            if (chan_ff == 2'd2) begin
               if (total_sum > TOTAL_W'(awb_limit_ff)) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: STATUS_AWB_RANGE,
                             failed_section: 4'd1 + 4'(check_ff)};
               end else if (!check_ff) begin
                  check_in = 1'b1;
                  chan_in  = '0;
                  total_in = '0;
                  state_in = ST_LOAD_U;
               end else begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_PASS, failed_section: 4'd0};
               end
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = ST_LOAD_U;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         sum_ff       <= '0;
         fail_ff      <= '0;
         group_ok_ff  <= 1'b1;
         module_ok_ff <= 1'b1;
         check_ff     <= 1'b0;
         chan_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         fail_ff      <= fail_in;
         group_ok_ff  <= group_ok_in;
         module_ok_ff <= module_ok_in;
         check_ff     <= check_in;
         chan_ff      <= chan_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      gold_ff <= gold_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         awb_limit_ff   <= AWB_LIMIT_RESET;
         vendor_id_ff   <= VENDOR_ID_RESET;
         lens_id_ff     <= LENS_ID_RESET;
         actuator_id_ff <= ACTUATOR_ID_RESET;
         driver_id_ff   <= DRIVER_ID_RESET;
         platform_id_ff <= PLATFORM_ID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AWB_LIMIT:   awb_limit_ff   <= csr_wdata;
            CSR_VENDOR_ID:   vendor_id_ff   <= csr_wdata[7:0];
            CSR_LENS_ID:     lens_id_ff     <= csr_wdata[7:0];
            CSR_ACTUATOR_ID: actuator_id_ff <= csr_wdata[7:0];
            CSR_DRIVER_ID:   driver_id_ff   <= csr_wdata[7:0];
            CSR_PLATFORM_ID: platform_id_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/civ_checker.sv =====
// Port-level checks on the validator's result channel.
module civ_checker
   import civ_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input civ_rsp_type rsp_data
);

   // A stalled result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Only defined status codes appear.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= STATUS_AWB_RANGE)
      else $error("undefined status");

   // A section index comes only with a checksum or white balance failure.
   a_section_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_CHECKSUM && rsp_data.status != STATUS_AWB_RANGE
      |-> rsp_data.failed_section == 4'd0)
      else $error("section index with wrong status");

   // White balance failures name one of the two color temperatures.
   a_awb_section: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_AWB_RANGE
      |-> rsp_data.failed_section == 4'd1 || rsp_data.failed_section == 4'd2)
      else $error("bad white balance section");

endmodule

bind calibration_image_validator civ_checker u_civ_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_calibration_image_validator.sv =====
// Self-checking testbench of the calibration image validator: full and aborted images.
`timescale 1ns / 100ps

module tb_calibration_image_validator;
   import civ_pkg::*;

   // Tracks expected verdicts: every accepted byte goes through a copy of the
   // validator's per-image state, and each result is matched to the oldest verdict.
   class verdict_board;
      logic [31:0] awb_limit;
      logic [7:0]  vendor, lens, actuator, driver, platform;
      int unsigned pos;
      int unsigned sec_sum;
      int unsigned first_bad;
      bit          flags_ok;
      bit          info_ok;
      logic [15:0] words [AWB_WORDS];
      civ_rsp_type pending_verdicts [$];
      int          errors;
      int          verdicts_seen;
      int          bytes_seen;

      function new();
         awb_limit = AWB_LIMIT_RESET;
         vendor = VENDOR_ID_RESET;
         lens = LENS_ID_RESET;
         actuator = ACTUATOR_ID_RESET;
         driver = DRIVER_ID_RESET;
         platform = PLATFORM_ID_RESET;
         errors = 0;
         verdicts_seen = 0;
         bytes_seen = 0;
         restart();
      endfunction

      function void restart();
         pos = 0;
         sec_sum = 0;
         first_bad = 0;
         flags_ok = 1;
         info_ok = 1;
      endfunction

      // One color temperature: three scaled squared relative errors summed.
      function bit balance_ok(int base);
         longint unsigned total, unit, gold, d;
         total = 0;
         for (int c = 0; c < 3; c++) begin
            unit = words[base + c];
            gold = words[base + c + 3];
            if (gold == 0) return 0;
            d = (unit > gold) ? unit - gold : gold - unit;
            total += (64'd1048576 * d * d) / (gold * gold);
         end
         return total <= longint'(awb_limit);
      endfunction

      // Advances the image state by one accepted item.
      function void note_byte(civ_req_type it);
         civ_rsp_type v;
         logic [7:0] b;
         int unsigned k;
         bytes_seen++;
         b = it.image_byte;
         if (it.read_failed) begin
            restart();
            v.status = STATUS_READ_FAILED;
            v.failed_section = 4'd0;
            pending_verdicts.push_back(v);
            return;
         end
         // Identity and version bytes.
         case (pos)
            POS_VENDOR:   if (b != vendor) info_ok = 0;
            POS_PLATFORM: if (b != platform) info_ok = 0;
            POS_LENS:     if (b != lens) info_ok = 0;
            POS_ACTUATOR: if (b != actuator) info_ok = 0;
            POS_DRIVER:   if (b != driver) info_ok = 0;
            POS_VER0, POS_VER1, POS_VER2: if (b != 0) info_ok = 0;
            POS_VER3:     if (b != 0 && b != 2 && b != 3) info_ok = 0;
            default: ;
         endcase
         // White balance words, high byte first.
         if (pos >= AWB_HI_FIRST && pos <= AWB_HI_LAST || pos >= AWB_LO_FIRST && pos <= AWB_LO_LAST)
         begin
            if (pos <= AWB_HI_LAST) k = (pos - AWB_HI_FIRST) >> 1;
            else k = 6 + ((pos - AWB_LO_FIRST) >> 1);
            if (((pos - AWB_HI_FIRST) & 1) == 0) words[k] = {b, 8'h00};
            else words[k][7:0] = b;
         end
         // Section flags and checksums.
         for (int s = 0; s < NUM_SECTIONS; s++) begin
            if (pos == SEC_FLAG[s]) begin
               sec_sum = 0;
               if (SEC_FLAG_CHECKED[s] && b != 1) flags_ok = 0;
            end else if (pos > SEC_FLAG[s] && pos < SEC_SUM_AT[s]) begin
               sec_sum = (sec_sum + b) & 32'h1FFFFF;
            end else if (pos == SEC_SUM_AT[s]) begin
               if (b != sec_sum % 255 + 1)
                  if (first_bad == 0 || s + 1 < first_bad) first_bad = s + 1;
            end
         end
         if (pos + 1 < IMAGE_BYTES) begin
            pos = (pos + 1) & 32'h3FFF;
            return;
         end
         // Last byte: first failure in priority order.
         v.status = STATUS_PASS;
         v.failed_section = 4'd0;
         if (!flags_ok) v.status = STATUS_GROUP;
         else if (!info_ok) v.status = STATUS_MODULE_INFO;
         else if (first_bad != 0) begin
            v.status = STATUS_CHECKSUM;
            v.failed_section = 4'(first_bad);
         end else if (!balance_ok(0)) begin
            v.status = STATUS_AWB_RANGE;
            v.failed_section = 4'd1;
         end else if (!balance_ok(6)) begin
            v.status = STATUS_AWB_RANGE;
            v.failed_section = 4'd2;
         end
         restart();
         pending_verdicts.push_back(v);
      endfunction

      function void check_verdict(civ_rsp_type got);
         civ_rsp_type want;
         verdicts_seen++;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result status %0d section %0d", $time, got.status,
                     got.failed_section);
            errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.failed_section !== want.failed_section) begin
            $display("%0t: failed_section expected %0d actual %0d", $time,
                     want.failed_section, got.failed_section);
            errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 400;

   // Image defect kinds for the generator.
   typedef enum int {
      DEFECT_NONE, DEFECT_FLAG, DEFECT_INFO, DEFECT_CHECKSUM, DEFECT_ZERO_GOLD,
      DEFECT_BIG_DEVIATION, DEFECT_ABORT
   } defect_kind_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   civ_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   civ_rsp_type rsp_data;
   logic        csr_we = 0;
   logic [2:0]  csr_index = CSR_AWB_LIMIT;
   logic [31:0] csr_wdata = 0;

   verdict_board board;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           cycles = 0;
   int           full_images = 0;
   logic [7:0]   img [IMAGE_BYTES];

   calibration_image_validator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Timeout guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_calibration_image_validator: errors");
         $finish;
      end
   end

   // Result side: take results and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_verdict(rsp_data);
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // Offers one item, with a random gap first, and waits until it is taken.
   task automatic send_byte(logic [7:0] b, logic fail);
      civ_req_type it;
      it.image_byte = b;
      it.read_failed = fail;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      board.note_byte(it);
   endtask

   // Leaves the write enable high; the caller drops it after the last write.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_AWB_LIMIT:   board.awb_limit = value;
         CSR_VENDOR_ID:   board.vendor = value[7:0];
         CSR_LENS_ID:     board.lens = value[7:0];
         CSR_ACTUATOR_ID: board.actuator = value[7:0];
         CSR_DRIVER_ID:   board.driver = value[7:0];
         CSR_PLATFORM_ID: board.platform = value[7:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (board.pending_verdicts.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Fills the image buffer with a well-formed image, then applies the given defect, if any.
   task automatic build_image(defect_kind_type defect);
      int unsigned gold, dev, unit, base, s, r;
      int unsigned sum;
      logic [POS_W-1:0] info_pos [9];
      info_pos = '{POS_VENDOR, POS_PLATFORM, POS_LENS, POS_ACTUATOR, POS_DRIVER,
                   POS_VER0, POS_VER1, POS_VER2, POS_VER3};
      foreach (img[i]) img[i] = $urandom;
      for (int k = 0; k < NUM_SECTIONS; k++)
         if (SEC_FLAG_CHECKED[k]) img[SEC_FLAG[k]] = 8'd1;
      img[POS_VENDOR] = board.vendor;
      img[POS_PLATFORM] = board.platform;
      img[POS_LENS] = board.lens;
      img[POS_ACTUATOR] = board.actuator;
      img[POS_DRIVER] = board.driver;
      img[POS_VER0] = 0;
      img[POS_VER1] = 0;
      img[POS_VER2] = 0;
      r = $urandom_range(2);
      img[POS_VER3] = (r == 0) ? 8'd0 : (r == 1) ? 8'd2 : 8'd3;
      // White balance: unit close to golden, sometimes exact, sometimes extreme.
      for (int t = 0; t < 2; t++) begin
         base = (t == 0) ? AWB_HI_FIRST : AWB_LO_FIRST;
         for (int c = 0; c < 3; c++) begin
            gold = $urandom_range(1, 65535);
            case ($urandom_range(9))
               0: dev = 0;
               1: dev = $urandom_range(0, gold);
               default: dev = $urandom_range(0, gold / 12);
            endcase
            unit = $urandom_range(1) ? gold + dev : gold - dev;
            if (unit > 65535) unit = 65535;
            if (defect == DEFECT_BIG_DEVIATION && $urandom_range(3) == 0) begin
               gold = 65535;
               unit = 0;
            end
            if (defect == DEFECT_ZERO_GOLD && $urandom_range(2) == 0) gold = 0;
            img[base + 2 * c] = unit[15:8];
            img[base + 2 * c + 1] = unit[7:0];
            img[base + 6 + 2 * c] = gold[15:8];
            img[base + 7 + 2 * c] = gold[7:0];
         end
      end
      if (defect == DEFECT_FLAG) begin
         do s = $urandom_range(NUM_SECTIONS - 1); while (!SEC_FLAG_CHECKED[s]);
         img[SEC_FLAG[s]] = 8'd1 + 8'($urandom_range(1, 255));
      end
      if (defect == DEFECT_INFO) begin
         s = $urandom_range(8);
         if (info_pos[s] == POS_VER3) img[info_pos[s]] = 8'($urandom_range(4, 255));
         else img[info_pos[s]] = img[info_pos[s]] + 8'($urandom_range(1, 255));
      end
      for (int k = 0; k < NUM_SECTIONS; k++) begin
         sum = 0;
         for (int p = SEC_FLAG[k] + 1; p < SEC_SUM_AT[k]; p++) sum += img[p];
         img[SEC_SUM_AT[k]] = 8'(sum % 255 + 1);
      end
      if (defect == DEFECT_CHECKSUM)
         repeat ($urandom_range(1, 2)) begin
            s = $urandom_range(NUM_SECTIONS - 1);
            img[SEC_SUM_AT[s]] = img[SEC_SUM_AT[s]] + 8'($urandom_range(1, 255));
         end
   endtask

   task automatic run_full_image();
      defect_kind_type defect;
      int unsigned stop_at;
      case ($urandom_range(11))
         0: defect = DEFECT_FLAG;
         1: defect = DEFECT_INFO;
         2: defect = DEFECT_CHECKSUM;
         3: defect = DEFECT_ZERO_GOLD;
         4: defect = DEFECT_BIG_DEVIATION;
         5: defect = DEFECT_ABORT;
         default: defect = DEFECT_NONE;
      endcase
      build_image(defect);
      stop_at = (defect == DEFECT_ABORT) ? $urandom_range(IMAGE_BYTES - 1) : IMAGE_BYTES;
      for (int i = 0; i < IMAGE_BYTES; i++) begin
         if (i == stop_at) begin
            send_byte($urandom, 1);
            return;
         end
         send_byte(img[i], 0);
      end
      full_images++;
   endtask

   // A short run of random bytes ended by a read failure.
   task automatic run_aborted_image();
      int unsigned len;
      len = ($urandom_range(4) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 40);
      repeat (len) send_byte($urandom, 0);
      send_byte($urandom, 1);
   endtask

   task automatic run_phase(int idle, int stall, int fulls, int aborts);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (aborts / 2) run_aborted_image();
      repeat (fulls) run_full_image();
      repeat (aborts - aborts / 2) run_aborted_image();
      wait_idle();
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: byte extremes and read failures at and after position zero.
      send_byte(8'h00, 1);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h5A, 1);
      send_byte(8'hFF, 1);
      wait_idle();

      // Reset configuration, no idling.
      run_phase(0, 0, 3, 15);

      // Widest limit, all-ones IDs; sender mostly idle.
      write_reg(CSR_AWB_LIMIT, 32'hFFFF_FFFF);
      write_reg(CSR_VENDOR_ID, 8'hFF);
      write_reg(CSR_LENS_ID, 8'hFF);
      write_reg(CSR_ACTUATOR_ID, 8'hFF);
      write_reg(CSR_DRIVER_ID, 8'hFF);
      write_reg(CSR_PLATFORM_ID, 8'hFF);
      csr_we <= 0;
      run_phase(88, 0, 1, 10);

      // Zero limit, zero IDs; receiver mostly stalling.
      write_reg(CSR_AWB_LIMIT, 32'd0);
      write_reg(CSR_VENDOR_ID, 8'h00);
      write_reg(CSR_LENS_ID, 8'h00);
      write_reg(CSR_ACTUATOR_ID, 8'h00);
      write_reg(CSR_DRIVER_ID, 8'h00);
      write_reg(CSR_PLATFORM_ID, 8'h00);
      csr_we <= 0;
      run_phase(0, 88, 2, 15);

      // Random limit and IDs; both sides idling now and then.
      write_reg(CSR_AWB_LIMIT, $urandom_range(2000, 40000));
      write_reg(CSR_VENDOR_ID, $urandom);
      write_reg(CSR_LENS_ID, $urandom);
      write_reg(CSR_ACTUATOR_ID, $urandom);
      write_reg(CSR_DRIVER_ID, $urandom);
      write_reg(CSR_PLATFORM_ID, $urandom);
      csr_we <= 0;
      run_phase(18, 18, 2, 15);

      $display("Covered %0d bytes, %0d results, %0d complete images, over four",
               board.bytes_seen, board.verdicts_seen, full_images);
      $display("register settings and four idle and stall patterns.");
      if (board.errors == 0 && board.pending_verdicts.size() == 0) begin
         $display("tb_calibration_image_validator: clean");
      end else begin
         $display("tb_calibration_image_validator: errors");
      end
      $finish;
   end

endmodule
